// ===== src/sorted_priority_queue_core_defines.svh =====
// Assertion macros shared by the sorted priority queue RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SPQ_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
	else $error("sorted priority queue check failed");
// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error("sorted priority queue sequencing check failed");
`else
`define SPQ_ASSERT(lbl, ck, rn, prop)
`define SPQ_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== src/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int PRIO_W    = 16;
	localparam int PAY_W     = 32;
	localparam int ENTRY_W   = PRIO_W + PAY_W;

	// Request codes.
	localparam logic [1:0] FN_ENQ  = 2'd0;
	localparam logic [1:0] FN_DEQ  = 2'd1;
	localparam logic [1:0] FN_PEEK = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_ENQ      = 5'b00010,
		S_ENQ_HEAD = 5'b00100,
		S_DEQ      = 5'b01000,
		S_PEEK     = 5'b10000
	} spq_state_t;

endpackage

// ===== src/sorted_priority_queue_core.sv =====
// Sorted priority queue: enqueue walks from the tail through one RAM port pair, 1 entry/cycle.
// Enqueue into an empty queue writes the front slot directly; dequeue shifts every entry one
// slot toward the front; peek reads the head; full, empty and unused codes finish without
// touching the store. One request at a time; busy is high until the request finishes.
// Results appear as a one-cycle done strobe and cannot be stalled by the receiver.
// arst_n clears the sequencer and the entry count at once; stored entries are not cleared.
`timescale 1ns / 1ps
`include "sorted_priority_queue_core_defines.svh"

module sorted_priority_queue_core
	import spq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       func,
	input  logic [PAY_W-1:0]                 payload,
	input  logic signed [PRIO_W-1:0]         priority_req,
	output logic                             done,
	output logic [PAY_W-1:0]                 out_payload,
	output logic [1:0]                       status,
	output logic [$clog2(DEPTH+1)-1:0]       occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Sequencer and bookkeeping registers.
	spq_state_t             state_q, state_d;
	logic [CW-1:0]          count_q, count_d;
	logic [AW-1:0]          idx_q, idx_d;
	logic                   done_q, done_d;
	logic [1:0]             status_q, status_d;
	logic [PAY_W-1:0]       outpay_q, outpay_d;

	// Request held for the length of a multi-cycle enqueue.
	logic signed [PRIO_W-1:0] req_prio_q;
	logic [PAY_W-1:0]         req_pay_q;

	// Entry RAM ports.
	logic               rd_en, wr_en;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic [ENTRY_W-1:0] wr_data, rd_data;

	logic                     accept;
	logic signed [PRIO_W-1:0] rd_prio;
	logic [PAY_W-1:0]         rd_pay;
	logic                     moves_back;

	// Each entry is stored as priority above payload.
	assign rd_prio = $signed(rd_data[ENTRY_W-1:PAY_W]);
	assign rd_pay  = rd_data[PAY_W-1:0];

	// The single shared compare: a stored entry that ranks strictly below the new one
	// moves one slot toward the tail. Equal priorities stay ahead, which keeps FIFO order.
	assign moves_back = (rd_prio < req_prio_q);

	assign accept = start && (state_q == S_IDLE);

	spq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Next-state logic. The RAM read is registered, so in every walking state the data
	// for idx_q arrives in the current cycle while the read for the next index is issued.
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		done_d   = 1'b0;
		status_d = status_q;
		outpay_d = outpay_q;
		rd_en    = 1'b0;
		rd_addr  = idx_q;
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_data  = rd_data;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_d = ST_OK;
					outpay_d = '0;
					case (func)
						FN_ENQ: begin
							if (count_q == CW'(DEPTH)) begin
								// Full queue: the entry is dropped.
								status_d = ST_FULL;
								done_d   = 1'b1;
							end else if (count_q == '0) begin
								// Empty queue: the entry goes straight to the front.
								wr_en   = 1'b1;
								wr_addr = '0;
								wr_data = {priority_req, payload};
								count_d = count_q + CW'(1);
								done_d  = 1'b1;
							end else begin
								// Start the walk at the tail.
								rd_en   = 1'b1;
								rd_addr = AW'(count_q - CW'(1));
								idx_d   = AW'(count_q - CW'(1));
								state_d = S_ENQ;
							end
						end
						FN_DEQ: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
								done_d   = 1'b1;
							end else begin
								rd_en   = 1'b1;
								rd_addr = '0;
								idx_d   = '0;
								state_d = S_DEQ;
							end
						end
						FN_PEEK: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
								done_d   = 1'b1;
							end else begin
								rd_en   = 1'b1;
								rd_addr = '0;
								state_d = S_PEEK;
							end
						end
						default: begin
							// Unused request code: report ok and leave the store alone.
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_ENQ: begin
				wr_en   = 1'b1;
				wr_addr = idx_q + AW'(1);
				if (moves_back) begin
					wr_data = rd_data;
					if (idx_q == '0) begin
						state_d = S_ENQ_HEAD;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q - AW'(1);
						idx_d   = idx_q - AW'(1);
					end
				end else begin
					// Insertion point found right behind this entry.
					wr_data = {req_prio_q, req_pay_q};
					count_d = count_q + CW'(1);
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_ENQ_HEAD: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = {req_prio_q, req_pay_q};
				count_d = count_q + CW'(1);
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_PEEK: begin
				outpay_d = rd_pay;
				done_d   = 1'b1;
				state_d  = S_IDLE;
			end
			S_DEQ: begin
				if (idx_q == '0) begin
					outpay_d = rd_pay;
				end else begin
					// Shift the entry one slot toward the front.
					wr_en   = 1'b1;
					wr_addr = idx_q - AW'(1);
					wr_data = rd_data;
				end
				if (CW'(idx_q) + CW'(1) == count_q) begin
					count_d = count_q - CW'(1);
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_q + AW'(1);
					idx_d   = idx_q + AW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			idx_q    <= '0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			done_q   <= done_d;
			status_q <= status_d;
			idx_q    <= idx_d;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		outpay_q <= outpay_d;
		if (accept) begin
			req_prio_q <= priority_req;
			req_pay_q  <= payload;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign out_payload = outpay_q;
	assign status      = status_q;
	assign occupancy   = count_q;

	`SPQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH))
	`SPQ_ASSERT(a_done_idle, clk, arst_n, !done_q || state_q == S_IDLE)
	`SPQ_ASSERT(a_enq_room, clk, arst_n, !(state_q == S_ENQ || state_q == S_ENQ_HEAD) || count_q < CW'(DEPTH))
	`SPQ_ASSERT(a_deq_nonempty, clk, arst_n, !(state_q == S_DEQ || state_q == S_PEEK) || count_q != '0)
	`SPQ_ASSERT(a_full_status, clk, arst_n, !(done_q && status_q == ST_FULL) || count_q == CW'(DEPTH))
	`SPQ_ASSERT_NEXT(a_head_done, clk, arst_n, state_q == S_ENQ_HEAD, done_q && status_q == ST_OK)

endmodule

// ===== src/spq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module spq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
